// ===== design/sha1mh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1mh_pkg
// Shared types, constants and round helpers for the SHA-1 message hasher.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

    localparam logic [31:0] K0       = 32'h5a82_7999;
    localparam logic [31:0] K1       = 32'h6ed9_eba1;
    localparam logic [31:0] K2       = 32'h8f1b_bcdc;
    localparam logic [31:0] K3       = 32'hca62_c1d6;
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    typedef logic [4:0][31:0] word5_t;

    localparam word5_t H_INIT = '{
        0: 32'h6745_2301,
        1: 32'hefcd_ab89,
        2: 32'h98ba_dcfe,
        3: 32'h1032_5476,
        4: 32'hc3d2_e1f0
    };

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [31:0] word;
    } sched_ctl_t;

    function automatic logic [31:0] lead_mask(input logic [2:0] n);
        logic [31:0] m;
        begin
            case (n)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'hff00_0000;
                3'd2:    m = 32'hffff_0000;
                3'd3:    m = 32'hffff_ff00;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        begin
            if (rnd < 7'd20)
                k = K0;
            else if (rnd < 7'd40)
                k = K1;
            else if (rnd < 7'd60)
                k = K2;
            else
                k = K3;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (rnd < 7'd20)
                f = (b & c) | (~b & d);
            else if (rnd < 7'd40)
                f = b ^ c ^ d;
            else if (rnd < 7'd60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

// ===== design/sha1mh_sched.sv =====
// ----------------------------------------------------------------------------
// sha1mh_sched
// Sixteen-word shift line holding the block and expanding the message schedule.
// ----------------------------------------------------------------------------
module sha1mh_sched (
    input  logic                   clk,
    input  sha1mh_pkg::sched_ctl_t ctl,
    output logic [31:0]            w
);

    logic [31:0] w_reg [sha1mh_pkg::BLOCK_WORDS];
    logic [31:0] mix;
    logic [31:0] expand;

    assign mix    = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign expand = {mix[30:0], mix[31]};
    assign w      = w_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.load || ctl.step)
        begin
            for (int i = 0; i < sha1mh_pkg::BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[sha1mh_pkg::BLOCK_WORDS - 1] <= ctl.load ? ctl.word : expand;
        end
    end

endmodule

// ===== design/sha1mh_round.sv =====
// ----------------------------------------------------------------------------
// sha1mh_round
// One SHA-1 round: round function, constant and working-variable rotation.
// ----------------------------------------------------------------------------
module sha1mh_round (
    input  sha1mh_pkg::word5_t vars,
    input  logic [31:0]        w,
    input  logic [6:0]         rnd,
    output sha1mh_pkg::word5_t vars_next
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] t;

    assign a = vars[0];
    assign b = vars[1];
    assign c = vars[2];
    assign d = vars[3];
    assign e = vars[4];

    assign t = {a[26:0], a[31:27]} + sha1mh_pkg::round_f(rnd, b, c, d) + e + w
             + sha1mh_pkg::round_k(rnd);

    always_comb
    begin
        vars_next[0] = t;
        vars_next[1] = a;
        vars_next[2] = {b[1:0], b[31:2]};
        vars_next[3] = c;
        vars_next[4] = d;
    end

endmodule

// ===== design/sha1_message_hasher_core.sv =====
// Flow: a data word is accepted only while idle; each full block then runs
// 80 rounds through the shared round unit, followed by a hash update.
// Last word: padding words are loaded and one or two block compressions run, then
// five digest words, one per cycle while the consumer is ready.
// Message words are not accepted while the single round unit compresses a block.
// Reset: asynchronous, active low; restores the initial hash and clears length.
// ----------------------------------------------------------------------------
// sha1_message_hasher_core
// SHA-1 hasher with padding sequencer, shared round unit and digest output.
// ----------------------------------------------------------------------------
module sha1_message_hasher_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     word_valid,
    output logic                     word_ready,
    input  sha1mh_pkg::msg_item_t    word_data,
    output logic                     digest_valid,
    input  logic                     digest_ready,
    output sha1mh_pkg::digest_item_t digest_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_UPD,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [4:0]         fill_reg, fill_next;
    logic [6:0]         rnd_reg, rnd_next;
    logic [63:0]        bitlen_reg, bitlen_next;
    logic               fin_reg, fin_next;
    logic               pad_done_reg, pad_done_next;
    logic               len_hi_reg, len_hi_next;
    logic [2:0]         idx_reg, idx_next;
    sha1mh_pkg::word5_t hash_reg, hash_next;
    sha1mh_pkg::word5_t vars_reg;
    sha1mh_pkg::word5_t round_out;

    sha1mh_pkg::sched_ctl_t ctl;
    logic [31:0]            w_cur;

    logic [2:0]  cnt_sat;
    logic [2:0]  n_bytes;
    logic [31:0] acc_word;
    logic        acc_shift;
    logic        start_comp;

    sha1mh_sched u_sched (
        .clk (clk),
        .ctl (ctl),
        .w   (w_cur)
    );

    sha1mh_round u_round (
        .vars      (vars_reg),
        .w         (w_cur),
        .rnd       (rnd_reg),
        .vars_next (round_out)
    );

    assign cnt_sat   = (word_data.byte_count > 3'd4) ? 3'd4 : word_data.byte_count;
    assign n_bytes   = word_data.last ? cnt_sat : 3'd4;
    assign acc_shift = (n_bytes != 3'd0) || word_data.last;
    assign acc_word  = (word_data.data_word & sha1mh_pkg::lead_mask(n_bytes))
                     | ((word_data.last && (n_bytes != 3'd4))
                        ? (sha1mh_pkg::PAD_WORD >> {n_bytes, 3'b000}) : 32'h0);

    assign word_ready   = (state_reg == S_IDLE);
    assign digest_valid = (state_reg == S_OUT);

    always_comb
    begin
        digest_data.digest_word = hash_reg[idx_reg];
        digest_data.word_index  = idx_reg;
        digest_data.last_word   = (idx_reg == 3'd4);
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rnd_next      = rnd_reg;
        bitlen_next   = bitlen_reg;
        fin_next      = fin_reg;
        pad_done_next = pad_done_reg;
        len_hi_next   = len_hi_reg;
        idx_next      = idx_reg;
        hash_next     = hash_reg;
        ctl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (word_valid)
                begin
                    ctl.load      = acc_shift;
                    ctl.word      = acc_word;
                    fill_next     = fill_reg + {4'b0, acc_shift};
                    bitlen_next   = bitlen_reg + {58'b0, n_bytes, 3'b000};
                    fin_next      = word_data.last;
                    pad_done_next = word_data.last && (n_bytes != 3'd4);
                    rnd_next      = '0;
                    if (fill_next == 5'd16)
                        state_next = S_COMP;
                    else if (word_data.last)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                ctl.load  = 1'b1;
                fill_next = fill_reg + 5'd1;
                rnd_next  = '0;
                if (!pad_done_reg)
                begin
                    ctl.word      = sha1mh_pkg::PAD_WORD;
                    pad_done_next = 1'b1;
                end
                else if (fill_reg == 5'd14)
                begin
                    ctl.word    = bitlen_reg[63:32];
                    len_hi_next = 1'b1;
                end
                else if ((fill_reg == 5'd15) && len_hi_reg)
                    ctl.word = bitlen_reg[31:0];
                else
                    ctl.word = 32'h0;
                if (fill_reg == 5'd15)
                    state_next = S_COMP;
            end
            S_COMP:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(sha1mh_pkg::ROUNDS - 1))
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                fill_next = '0;
                idx_next  = '0;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (len_hi_reg)
                    state_next = S_OUT;
                else
                    state_next = S_PAD;
            end
            S_OUT:
            begin
                if (digest_ready)
                begin
                    if (idx_reg == 3'd4)
                    begin
                        hash_next     = sha1mh_pkg::H_INIT;
                        bitlen_next   = '0;
                        fill_next     = '0;
                        fin_next      = 1'b0;
                        pad_done_next = 1'b0;
                        len_hi_next   = 1'b0;
                        idx_next      = '0;
                        state_next    = S_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign start_comp = (state_next == S_COMP) && (state_reg != S_COMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            rnd_reg      <= '0;
            bitlen_reg   <= '0;
            fin_reg      <= 1'b0;
            pad_done_reg <= 1'b0;
            len_hi_reg   <= 1'b0;
            idx_reg      <= '0;
            hash_reg     <= sha1mh_pkg::H_INIT;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rnd_reg      <= rnd_next;
            bitlen_reg   <= bitlen_next;
            fin_reg      <= fin_next;
            pad_done_reg <= pad_done_next;
            len_hi_reg   <= len_hi_next;
            idx_reg      <= idx_next;
            hash_reg     <= hash_next;
        end
    end

    // load working variables on entry, then advance one round per cycle
    always_ff @(posedge clk)
    begin
        if (start_comp)
            vars_reg <= hash_reg;
        else if (state_reg == S_COMP)
            vars_reg <= round_out;
    end

endmodule

// ===== design/sha1mh_checker.sv =====
// ----------------------------------------------------------------------------
// sha1mh_checker
// Port-level assertions for the SHA-1 message hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1mh_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     word_valid,
    input logic                     word_ready,
    input sha1mh_pkg::msg_item_t    word_data,
    input logic                     digest_valid,
    input logic                     digest_ready,
    input sha1mh_pkg::digest_item_t digest_data
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(word_ready && digest_valid))
        else $error("request taken while digest pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest_data))
        else $error("stalled digest word changed");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest_data.last_word
        |=> digest_valid && (digest_data.word_index == $past(digest_data.word_index) + 3'd1))
        else $error("digest word index did not advance");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest_data.last_word == (digest_data.word_index == 3'd4)))
        else $error("last_word flag mismatch");

    a_no_early_digest: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_ready && !word_data.last |=> !digest_valid)
        else $error("digest after non-final request");

endmodule

bind sha1_message_hasher_core sha1mh_checker u_sha1mh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word_data    (word_data),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_data  (digest_data)
);
